@@ sv/pcx_rle_line_decoder_macros.svh @@
// Assertion macros shared by the PCX RLE line decoder
`ifndef PCX_RLE_LINE_DECODER_MACROS_SVH
`define PCX_RLE_LINE_DECODER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PCX_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PCX_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/pcx_pkg.sv @@
// Types and constants shared by the PCX RLE line decoder modules
package pcx_pkg;

    localparam logic [7:0] RUN_MARK = 8'hC0;
    localparam logic [7:0] RUN_MASK = 8'h3F;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_MODE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BYTES_PER_LINE = 2'd1;

    typedef struct packed {
        logic        command;
        logic [7:0]  data_byte;
        logic [7:0]  palette_index;
        logic [15:0] palette_value;
    } pcx_item_t;

    typedef struct packed {
        logic [15:0] pixel;
        logic        last_of_run;
        logic        end_of_line;
    } pcx_result_t;

    typedef enum logic {
        OP_PAL_WRITE = 1'b0,
        OP_EMIT      = 1'b1
    } pcx_op_t;

    // Work entry passed from front to back
    typedef struct packed {
        pcx_op_t     op;
        logic [7:0]  index;    // pixel byte, or palette address for a write
        logic [15:0] value;    // palette color for a write
        logic [5:0]  count;    // pixels to emit, never zero for OP_EMIT
        logic        eol;      // line ends on the last pixel
    } pcx_cmd_t;

    typedef enum logic {
        BK_IDLE = 1'b0,
        BK_RUN  = 1'b1
    } pcx_back_state_t;

endpackage

@@ sv/pcx_front.sv @@
// Front end: accepts stream items, tracks run and line state, issues work entries
module pcx_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  pcx_pkg::pcx_item_t item,
    input  logic [15:0]       bytes_per_line,
    output logic              q_push,
    output pcx_pkg::pcx_cmd_t q_entry
);
    import pcx_pkg::*;

    logic        run_pending_reg, run_pending_next;
    logic [5:0]  run_length_reg, run_length_next;
    logic [15:0] pixels_done_reg, pixels_done_next;

    logic [5:0]  count_w;
    logic [16:0] total_w;
    logic        eol_w;

    always_comb
    begin
        run_pending_next = run_pending_reg;
        run_length_next  = run_length_reg;
        pixels_done_next = pixels_done_reg;
        count_w          = 6'd0;
        q_push           = 1'b0;
        total_w          = 17'd0;
        eol_w            = 1'b0;

        q_entry.op    = OP_PAL_WRITE;
        q_entry.index = item.palette_index;
        q_entry.value = item.palette_value;
        q_entry.count = 6'd0;
        q_entry.eol   = 1'b0;

        if (accept)
        begin
            if (item.command)
            begin
                q_push = 1'b1;
            end
            else
            begin
                if (run_pending_reg)
                begin
                    count_w          = run_length_reg;
                    run_pending_next = 1'b0;
                    run_length_next  = 6'd0;
                end
                else if (item.data_byte >= RUN_MARK)
                begin
                    run_pending_next = 1'b1;
                    run_length_next  = 6'(item.data_byte & RUN_MASK);
                end
                else
                begin
                    count_w = 6'd1;
                end

                total_w = {1'b0, pixels_done_reg} + 17'(count_w);
                eol_w   = total_w >= {1'b0, bytes_per_line};

                if (count_w != 6'd0)
                begin
                    q_push           = 1'b1;
                    pixels_done_next = eol_w ? 16'd0 : total_w[15:0];
                    q_entry.op       = OP_EMIT;
                    q_entry.index    = item.data_byte;
                    q_entry.count    = count_w;
                    q_entry.eol      = eol_w;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_pending_reg <= 1'b0;
            run_length_reg  <= 6'd0;
            pixels_done_reg <= 16'd0;
        end
        else
        begin
            run_pending_reg <= run_pending_next;
            run_length_reg  <= run_length_next;
            pixels_done_reg <= pixels_done_next;
        end
    end

endmodule

@@ sv/pcx_queue.sv @@
// Short work queue between front and back
module pcx_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pcx_pkg::pcx_cmd_t push_entry,
    output logic              full,
    output logic              valid,
    input  logic              pop,
    output pcx_pkg::pcx_cmd_t head
);
    import pcx_pkg::*;

    pcx_cmd_t               slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_PTR_W:0]   fill_reg, fill_next;

    assign full  = fill_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
    assign valid = fill_reg != '0;
    assign head  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

@@ sv/pcx_back.sv @@
// Back end: palette memory, run expansion and result register
module pcx_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 output_mode,
    input  logic                 q_valid,
    input  pcx_pkg::pcx_cmd_t    q_head,
    output logic                 q_pop,
    output logic                 res_valid,
    output pcx_pkg::pcx_result_t res,
    input  logic                 res_pop
);
    import pcx_pkg::*;

    pcx_back_state_t state_reg, state_next;

    logic [15:0] palette [256];
    logic [15:0] rd_data_reg;
    logic [7:0]  byte_reg;
    logic        eol_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        out_valid_reg, out_valid_next;
    pcx_result_t out_reg;

    logic        out_free;
    logic        mem_we;
    logic        load;
    logic        emit;
    pcx_result_t res_w;

    assign out_free = !out_valid_reg || res_pop;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid && q_head.op == OP_EMIT)
                begin
                    state_next = BK_RUN;
                end
            end
            BK_RUN:
            begin
                if (out_free && cnt_reg == 6'd1)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        q_pop  = 1'b0;
        mem_we = 1'b0;
        load   = 1'b0;
        emit   = 1'b0;
        unique case (state_reg)
            BK_IDLE:
            begin
                q_pop  = q_valid;
                mem_we = q_valid && q_head.op == OP_PAL_WRITE;
                load   = q_valid && q_head.op == OP_EMIT;
            end
            BK_RUN:
            begin
                emit = out_free;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        res_w.pixel       = output_mode ? rd_data_reg : {8'd0, byte_reg};
        res_w.last_of_run = cnt_reg == 6'd1;
        res_w.end_of_line = (cnt_reg == 6'd1) && eol_reg;

        cnt_next = cnt_reg;
        if (load)
        begin
            cnt_next = q_head.count;
        end
        else if (emit)
        begin
            cnt_next = cnt_reg - 6'd1;
        end

        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_pop)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            palette[q_head.index] <= q_head.value;
        end
        if (load)
        begin
            rd_data_reg <= palette[q_head.index];
            byte_reg    <= q_head.index;
            eol_reg     <= q_head.eol;
        end
        if (emit)
        begin
            out_reg <= res_w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            cnt_reg       <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

endmodule

@@ sv/pcx_rle_line_decoder.sv @@
// PCX RLE line decoder: a queue-style block that turns a PCX run-length
// stream into pixels. Each item is either a stream byte or a palette write.
// A byte of 0xC0 or above arms a run of (byte & 0x3F); the next byte is then
// emitted that many times (zero emits nothing). Other bytes emit once. In
// output_mode 1 each pixel is looked up in a 256 x 16 palette; in mode 0 it is
// the byte itself. end_of_line marks the last pixel of the byte that brings
// the line count to bytes_per_line or beyond. Timing: the front takes one
// item per cycle into a 4-entry work queue; markers and zero runs never
// enter it. The back takes one queued entry at a time: it uses the palette
// memory port (write, or registered read) and then, for an emit, sends its
// pixels one by one into the output register before taking the next entry.
// Input is held off only while the work queue is full. One finished result
// waits in the output register; while it is not popped the back stalls on
// its next pixel, and the queue then fills and holds off the input.
// The palette holds garbage until written; reading an unwritten entry in
// mode 1 gives an undefined pixel.
module pcx_rle_line_decoder (
    input  logic                              clk,
    input  logic                              rst_n,
    // item side
    input  logic                              push,
    output logic                              full,
    input  pcx_pkg::pcx_item_t                item,
    // result side
    output logic                              empty,
    input  logic                              pop,
    output pcx_pkg::pcx_result_t              result,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [pcx_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [15:0]                       cfg_data
);
    import pcx_pkg::*;

`include "pcx_rle_line_decoder_macros.svh"

    logic        output_mode_reg, output_mode_next;
    logic [15:0] bytes_per_line_reg, bytes_per_line_next;

    logic        accept;
    logic        q_push;
    pcx_cmd_t    q_entry;
    logic        q_full;
    logic        q_valid;
    logic        q_pop;
    pcx_cmd_t    q_head;
    logic        res_valid;

    // Registers are always writable; the user makes writes only while idle, as the block does not enforce it
    assign cfg_ready = 1'b1;

    always_comb
    begin
        output_mode_next    = output_mode_reg;
        bytes_per_line_next = bytes_per_line_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_OUTPUT_MODE:    output_mode_next    = cfg_data[0];
                CFG_BYTES_PER_LINE: bytes_per_line_next = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            output_mode_reg    <= 1'b0;
            bytes_per_line_reg <= 16'd1;
        end
        else
        begin
            output_mode_reg    <= output_mode_next;
            bytes_per_line_reg <= bytes_per_line_next;
        end
    end

    // A transaction is taken whenever the work queue has room
    assign full   = q_full;
    assign accept = push && !q_full;

    pcx_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .item           (item),
        .bytes_per_line (bytes_per_line_reg),
        .q_push         (q_push),
        .q_entry        (q_entry)
    );

    pcx_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .valid      (q_valid),
        .pop        (q_pop),
        .head       (q_head)
    );

    pcx_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .output_mode (output_mode_reg),
        .q_valid     (q_valid),
        .q_head      (q_head),
        .q_pop       (q_pop),
        .res_valid   (res_valid),
        .res         (result),
        .res_pop     (pop)
    );

    assign empty = !res_valid;

    // end of line only ever rides on the last pixel of a byte
    `PCX_ASSERT_IMPLY(a_eol_on_last, !empty && result.end_of_line, result.last_of_run, "end_of_line without last_of_run")
    // back never pops an empty work queue
    `PCX_ASSERT_IMPLY(a_pop_has_entry, q_pop, q_valid, "work queue popped while empty")
    // front never writes into a full work queue
    `PCX_ASSERT_IMPLY(a_push_has_room, q_push, !q_full, "work queue pushed while full")
    // a queued emit leaves the back busy with at least one pixel
    `PCX_ASSERT_NEXT(a_emit_nonzero, q_pop && q_head.op == OP_EMIT, u_back.state_reg == BK_RUN, "empty run reached back")

endmodule
